### design/assert_macros.svh
// assertion macros shared by the voxel fill block
// no dependencies; included inside module bodies that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define VRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define VRF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/vrf_pkg.sv
// types and constants of the voxel region fill and face mask block
// no dependencies
package vrf_pkg;

  // internal signed coordinate width, covers origin plus extent
  localparam int CW           = 10;
  localparam int IN_TDATA_W   = 56;
  localparam int OUT_TDATA_W  = 16;
  localparam int TYPE_FIELD_W = 4;
  localparam int MASK_W       = 6;

  // item kinds
  localparam logic KIND_FILL  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // fill modes
  localparam logic [1:0] MODE_SOLID = 2'd0;
  localparam logic [1:0] MODE_SHELL = 2'd1;
  localparam logic [1:0] MODE_EDGES = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_QUERY,
    ST_DONE
  } state_t;

  // query read sequence: center cell, then +x,-x,+y,-y,+z,-z
  typedef logic signed [1:0] step_t;
  localparam logic [2:0] NB_LAST = 3'd7;
  localparam step_t NB_STEP [8][3] = '{
    '{ 2'sd0,  2'sd0,  2'sd0},
    '{ 2'sd1,  2'sd0,  2'sd0},
    '{-2'sd1,  2'sd0,  2'sd0},
    '{ 2'sd0,  2'sd1,  2'sd0},
    '{ 2'sd0, -2'sd1,  2'sd0},
    '{ 2'sd0,  2'sd0,  2'sd1},
    '{ 2'sd0,  2'sd0, -2'sd1},
    '{ 2'sd0,  2'sd0,  2'sd0}
  };

endpackage

### design/voxel_region_fill_and_face_mask_top.sv
// voxel region fill and face exposure query, top level
// depends on vrf_pkg and assert_macros.svh
//
// usage
//   input beats carry either a box fill (tuser 0) or a single cell query
//   (tuser 1); every input beat yields exactly one output beat.
//   a fill writes new_type over the box origin pos, size extent, in solid,
//   shell or edges mode; cells off the grid are skipped. it answers only
//   coord_valid 1. a query answers the cell type, solidity and a mask of the
//   six faces whose neighbor is off the grid or empty; off grid it answers 0.
// timing
//   after reset a clearing pass writes every cell to empty, one cell a
//   cycle, with in_tready low throughout.
//   a fill walks the clipped box one cell a cycle, as the store has a single
//   write port; a query makes seven reads through the single read port; an
//   off-grid query or an empty fill goes straight to its result.
//   one item is worked at a time; in_tready is high only while idle.
// stalls
//   the result sits in an output register; the next item is taken while it
//   waits, and that item's result is held back until the register frees.
module voxel_region_fill_and_face_mask_top #(
  parameter int SIDE_LOG2    = 5,
  parameter int HEIGHT_CELLS = 32,
  parameter int TYPE_BITS    = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // fill_mode[1:0], pos_x[9:2], pos_y[17:10], pos_z[25:18], extent_x[33:26],
  // extent_y[41:34], extent_z[49:42], new_type[53:50], zero pad[55:54]
  input  logic [vrf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cell_type[3:0], is_solid[4], exposure_mask[10:5], coord_valid[11],
  // zero pad[15:12]
  output logic [vrf_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import vrf_pkg::*;

  localparam int SIDE_CELLS = 1 << SIDE_LOG2;
  localparam int ZB         = $clog2(HEIGHT_CELLS);
  localparam int ADDR_W     = 2 * SIDE_LOG2 + ZB;
  localparam int DEPTH      = SIDE_CELLS * SIDE_CELLS * HEIGHT_CELLS;
  localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic signed [CW-1:0] SIDE_LIM = CW'(SIDE_CELLS);
  localparam logic signed [CW-1:0] HGT_LIM  = CW'(HEIGHT_CELLS);
  localparam logic signed [CW-1:0] ONE_C    = CW'(1);
  localparam logic signed [CW-1:0] ZERO_C   = '0;

  typedef logic signed [CW-1:0] coord_t;

  function automatic logic in_grid(input coord_t x, input coord_t y, input coord_t z);
    return !x[CW-1] && (x < SIDE_LIM) && !y[CW-1] && (y < SIDE_LIM) &&
           !z[CW-1] && (z < HGT_LIM);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input coord_t x, input coord_t y,
                                                  input coord_t z);
    return {z[ZB-1:0], y[SIDE_LOG2-1:0], x[SIDE_LOG2-1:0]};
  endfunction

  // sign or zero extend an 8-bit field to coordinate width
  function automatic coord_t sext8(input logic [7:0] v);
    return {{(CW-8){v[7]}}, v};
  endfunction

  function automatic coord_t zext8(input logic [7:0] v);
    return {{(CW-8){1'b0}}, v};
  endfunction

  // voxel store
  logic [TYPE_BITS-1:0] store_mem [DEPTH];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  logic [TYPE_BITS-1:0] mem_wd;
  logic [ADDR_W-1:0]    rd_addr;
  logic [TYPE_BITS-1:0] rd_data_r;

  // sequencer and datapath registers
  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic                 kind_r, kind_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic [TYPE_BITS-1:0] code_r, code_nxt;
  coord_t               ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  coord_t               ex_r, ey_r, ez_r, ex_nxt, ey_nxt, ez_nxt;
  coord_t               mx_r, my_r, mz_r, mx_nxt, my_nxt, mz_nxt;
  coord_t               lox_r, loy_r, loz_r, lox_nxt, loy_nxt, loz_nxt;
  coord_t               hix_r, hiy_r, hiz_r, hix_nxt, hiy_nxt, hiz_nxt;
  coord_t               cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [2:0]           q_step_r, q_step_nxt;
  logic                 inb_r, inb_nxt;
  logic [TYPE_BITS-1:0] res_type_r, res_type_nxt;
  logic [MASK_W-1:0]    res_mask_r, res_mask_nxt;
  logic                 res_cv_r, res_cv_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // combinational helpers
  logic   in_fire;
  logic   out_free;
  coord_t mx_c, my_c, mz_c, lox_c, loy_c, loz_c, hix_c, hiy_c, hiz_c;
  logic   fill_go;
  logic   fx, fy, fz, put;
  logic   last_x, last_y, last_z;
  coord_t nx, ny, nz;
  logic   nb_in;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // box bounds, clipped to the grid
  always_comb begin
    mx_c  = ox_r + ex_r - ONE_C;
    my_c  = oy_r + ey_r - ONE_C;
    mz_c  = oz_r + ez_r - ONE_C;
    lox_c = ox_r[CW-1] ? ZERO_C : ox_r;
    loy_c = oy_r[CW-1] ? ZERO_C : oy_r;
    loz_c = oz_r[CW-1] ? ZERO_C : oz_r;
    hix_c = (mx_c > SIDE_LIM - ONE_C) ? SIDE_LIM - ONE_C : mx_c;
    hiy_c = (my_c > SIDE_LIM - ONE_C) ? SIDE_LIM - ONE_C : my_c;
    hiz_c = (mz_c > HGT_LIM - ONE_C) ? HGT_LIM - ONE_C : mz_c;
    fill_go = (mode_r == MODE_SOLID || mode_r == MODE_SHELL || mode_r == MODE_EDGES) &&
              (ex_r != ZERO_C) && (ey_r != ZERO_C) && (ez_r != ZERO_C) &&
              (lox_c <= hix_c) && (loy_c <= hiy_c) && (loz_c <= hiz_c);
  end

  // face test of the walk cursor
  always_comb begin
    fx = (cx_r == ox_r) || (cx_r == mx_r);
    fy = (cy_r == oy_r) || (cy_r == my_r);
    fz = (cz_r == oz_r) || (cz_r == mz_r);
    unique case (mode_r)
      MODE_SOLID: put = 1'b1;
      MODE_SHELL: put = fx || fy || fz;
      MODE_EDGES: put = (fx && fy) || (fx && fz) || (fy && fz);
      default:    put = 1'b0;
    endcase
    last_x = (cx_r == hix_r);
    last_y = (cy_r == hiy_r);
    last_z = (cz_r == hiz_r);
  end

  // neighbor coordinate for the current query step
  always_comb begin
    nx    = ox_r + CW'(NB_STEP[q_step_r][0]);
    ny    = oy_r + CW'(NB_STEP[q_step_r][1]);
    nz    = oz_r + CW'(NB_STEP[q_step_r][2]);
    nb_in = in_grid(nx, ny, nz);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (kind_r == KIND_QUERY) begin
          state_nxt = in_grid(ox_r, oy_r, oz_r) ? ST_QUERY : ST_DONE;
        end else begin
          state_nxt = fill_go ? ST_FILL : ST_DONE;
        end
      end
      ST_FILL: begin
        if (last_x && last_y && last_z) state_nxt = ST_DONE;
      end
      ST_QUERY: begin
        if (q_step_r == NB_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    mem_we         = 1'b0;
    mem_wa         = cell_addr(cx_r, cy_r, cz_r);
    mem_wd         = code_r;
    rd_addr        = cell_addr(nx, ny, nz);
    clr_addr_nxt   = clr_addr_r;
    kind_nxt       = kind_r;
    mode_nxt       = mode_r;
    code_nxt       = code_r;
    ox_nxt = ox_r;  oy_nxt = oy_r;  oz_nxt = oz_r;
    ex_nxt = ex_r;  ey_nxt = ey_r;  ez_nxt = ez_r;
    mx_nxt = mx_r;  my_nxt = my_r;  mz_nxt = mz_r;
    lox_nxt = lox_r; loy_nxt = loy_r; loz_nxt = loz_r;
    hix_nxt = hix_r; hiy_nxt = hiy_r; hiz_nxt = hiz_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;
    q_step_nxt     = q_step_r;
    inb_nxt        = inb_r;
    res_type_nxt   = res_type_r;
    res_mask_nxt   = res_mask_r;
    res_cv_nxt     = res_cv_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        mem_wd       = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt = in_tuser;
          mode_nxt = in_tdata[1:0];
          ox_nxt   = sext8(in_tdata[9:2]);
          oy_nxt   = sext8(in_tdata[17:10]);
          oz_nxt   = sext8(in_tdata[25:18]);
          ex_nxt   = zext8(in_tdata[33:26]);
          ey_nxt   = zext8(in_tdata[41:34]);
          ez_nxt   = zext8(in_tdata[49:42]);
          code_nxt = TYPE_BITS'(in_tdata[53:50]);
        end
      end
      ST_SETUP: begin
        mx_nxt = mx_c;  my_nxt = my_c;  mz_nxt = mz_c;
        lox_nxt = lox_c; loy_nxt = loy_c; loz_nxt = loz_c;
        hix_nxt = hix_c; hiy_nxt = hiy_c; hiz_nxt = hiz_c;
        cx_nxt = lox_c; cy_nxt = loy_c; cz_nxt = loz_c;
        q_step_nxt   = '0;
        res_type_nxt = '0;
        res_mask_nxt = '0;
        // fills and on-grid queries answer coord_valid 1
        res_cv_nxt   = (kind_r == KIND_FILL) || in_grid(ox_r, oy_r, oz_r);
      end
      ST_FILL: begin
        mem_we = put;
        // walk x fastest, then y, then z
        if (last_x) begin
          cx_nxt = lox_r;
          if (last_y) begin
            cy_nxt = loy_r;
            cz_nxt = cz_r + ONE_C;
          end else begin
            cy_nxt = cy_r + ONE_C;
          end
        end else begin
          cx_nxt = cx_r + ONE_C;
        end
      end
      ST_QUERY: begin
        inb_nxt    = nb_in;
        q_step_nxt = q_step_r + 3'd1;
        // read data of the previous step lands in rd_data_r
        if (q_step_r == 3'd1) begin
          res_type_nxt = rd_data_r;
        end else if (q_step_r != 3'd0) begin
          res_mask_nxt = {!inb_r || (rd_data_r == '0), res_mask_r[MASK_W-1:1]};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {4'b0000, res_cv_r, res_mask_r, (res_type_r != '0),
                            TYPE_FIELD_W'(res_type_r)};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      q_step_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      q_step_r     <= q_step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    mode_r <= mode_nxt;
    code_r <= code_nxt;
    ox_r <= ox_nxt;  oy_r <= oy_nxt;  oz_r <= oz_nxt;
    ex_r <= ex_nxt;  ey_r <= ey_nxt;  ez_r <= ez_nxt;
    mx_r <= mx_nxt;  my_r <= my_nxt;  mz_r <= mz_nxt;
    lox_r <= lox_nxt; loy_r <= loy_nxt; loz_r <= loz_nxt;
    hix_r <= hix_nxt; hiy_r <= hiy_nxt; hiz_r <= hiz_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;
    inb_r       <= inb_nxt;
    res_type_r  <= res_type_nxt;
    res_mask_r  <= res_mask_nxt;
    res_cv_r    <= res_cv_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `include "assert_macros.svh"

  `VRF_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == ST_CLEAR, "reset must start clearing pass")
  `VRF_ASSERT(a_write_state, mem_we |-> (state_r == ST_CLEAR || state_r == ST_FILL), "store written outside clear or fill")
  `VRF_ASSERT(a_walk_x, state_r == ST_FILL |-> (cx_r >= lox_r && cx_r <= hix_r && !cx_r[CW-1]), "fill cursor x out of box")
  `VRF_ASSERT(a_walk_yz, state_r == ST_FILL |-> (cy_r >= loy_r && cy_r <= hiy_r && cz_r >= loz_r && cz_r <= hiz_r), "fill cursor y or z out of box")
  `VRF_ASSERT(a_out_from_done, $rose(out_tvalid_r) |-> $past(state_r) == ST_DONE, "result raised outside done state")

endmodule
